// ===== rtl/core/spht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the strided-probe slot table core.
// No dependencies; imported by spht_rem and the top level.
package spht_pkg;

	// Defaults for the top-level parameters
	localparam int TABLE_SLOTS_DEF = 1024;
	localparam int ID_WIDTH_DEF    = 32;

	// Fixed field widths
	localparam int SLOT_W   = 10;
	localparam int COUNT_W  = 10;
	localparam int STATUS_W = 2;
	localparam int TSIZE_W  = 11;
	localparam int STEP_W   = 10;

	// Config port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_ADDR_W-1:0] REG_TABLE_SIZE = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PROBE_STEP = 1'd1;
	localparam logic [TSIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;
	localparam logic [STEP_W-1:0]  PROBE_STEP_RST = 10'd1;

	// Operation kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

	// Remainder unit: one numerator bit per cycle
	localparam int MOD_STEPS = 10;
	localparam int MCNT_W    = $clog2(MOD_STEPS);

	// Control from sequencer to remainder unit
	typedef struct packed {
		logic load;
		logic run;
	} rem_ctl_t;

endpackage

// ===== rtl/core/spht_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/spht_rem.sv =====
`timescale 1ns / 1ps
// Bit-serial remainder unit: num mod size, one numerator bit per cycle.
// Depends on spht_pkg.
module spht_rem
	import spht_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic                                 clk,
	input  rem_ctl_t                             ctl,
	input  logic [STEP_W-1:0]                    num,
	input  logic [$clog2(TABLE_SLOTS+1)-1:0]     size,
	output logic [$clog2(TABLE_SLOTS)-1:0]       rem
);

	localparam int SW = $clog2(TABLE_SLOTS + 1);
	localparam int AW = $clog2(TABLE_SLOTS);

	logic [STEP_W-1:0] num_q;
	logic [AW-1:0]     rem_q;
	logic [SW:0]       trial;
	logic [SW:0]       size_x;

	// shift in next numerator bit, subtract size if it fits
	assign trial  = (SW+1)'({rem_q, num_q[STEP_W-1]});
	assign size_x = (SW+1)'(size);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_q <= num;
			rem_q <= '0;
		end else if (ctl.run) begin
			num_q <= {num_q[STEP_W-2:0], 1'b0};
			if (trial >= size_x) begin
				rem_q <= AW'(trial - size_x);
			end else begin
				rem_q <= AW'(trial);
			end
		end
	end

	assign rem = rem_q;

endmodule

// ===== rtl/core/strided_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
// Strided-probe slot table core. Depends on spht_pkg, spht_ram, spht_rem.
// Steps: home/step reduction, setup, probe walk (registered RAM read), output register.
// A new item is taken only once the previous walk has ended and busy is low;
// the walk is limited by one RAM read per probe.
// Reset: after arst_n releases, a clearing pass over all TABLE_SLOTS slots holds busy high.
// done is a one-cycle strobe; the receiver cannot stall results.
module strided_probe_hash_table_core
	import spht_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [ID_WIDTH-1:0]   entry_id,
	input  logic [SLOT_W-1:0]     home_slot,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// result channel
	output logic                  done,
	output logic [SLOT_W-1:0]     slot,
	output logic [COUNT_W-1:0]    probe_count,
	output logic [STATUS_W-1:0]   status
);

	localparam int SW = $clog2(TABLE_SLOTS + 1);
	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = (SW > TSIZE_W) ? SW : TSIZE_W;
	localparam int MW = ID_WIDTH + 1;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_SETUP = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;

	logic [2:0]          state_q;
	logic [TSIZE_W-1:0]  table_size_q;
	logic [STEP_W-1:0]   probe_step_q;
	logic [AW-1:0]       clr_q;
	logic [MCNT_W-1:0]   mcnt_q;
	logic                kind_q;
	logic [ID_WIDTH-1:0] id_q;

	logic [AW-1:0]       rd_pos_q;
	logic                issue_q;
	logic                chk_vld_s1;
	logic [AW-1:0]       chk_pos_s1;
	logic                chk_last_s1;
	logic [SW-1:0]       passed_q;

	logic                done_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  probe_q;
	logic [STATUS_W-1:0] status_q;

	logic [SW-1:0]       size;
	logic [CW-1:0]       tsz_x;
	rem_ctl_t            rem_ctl;
	logic [STEP_W-1:0]   home_num;
	logic [STEP_W-1:0]   step_num;
	logic [AW-1:0]       home_rem;
	logic [AW-1:0]       step_rem;
	logic [SW:0]         pos_sum;
	logic [AW-1:0]       nxt_pos;
	logic                nxt_home;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [MW-1:0]       ram_wdata;
	logic                ram_re;
	logic [MW-1:0]       ram_rdata;
	logic                hit;
	logic                finish;

	// effective table size: zero acts as one, clamp to TABLE_SLOTS
	assign tsz_x = CW'(table_size_q);
	always_comb begin
		if (tsz_x == '0) begin
			size = SW'(1);
		end else if (tsz_x > CW'(TABLE_SLOTS)) begin
			size = SW'(TABLE_SLOTS);
		end else begin
			size = SW'(tsz_x);
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
			probe_step_q <= PROBE_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TABLE_SIZE: table_size_q <= cfg_wdata[TSIZE_W-1:0];
				REG_PROBE_STEP: probe_step_q <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// delete scans from slot 0 with stride 1
	assign home_num = (kind == KIND_DELETE) ? '0 : home_slot;
	assign step_num = (kind == KIND_DELETE) ? STEP_W'(1) : probe_step_q;
	assign rem_ctl.load = (state_q == S_IDLE) && start;
	assign rem_ctl.run  = (state_q == S_MOD);

	spht_rem #(.TABLE_SLOTS(TABLE_SLOTS)) u_home_rem (
		.clk  (clk),
		.ctl  (rem_ctl),
		.num  (home_num),
		.size (size),
		.rem  (home_rem)
	);

	spht_rem #(.TABLE_SLOTS(TABLE_SLOTS)) u_step_rem (
		.clk  (clk),
		.ctl  (rem_ctl),
		.num  (step_num),
		.size (size),
		.rem  (step_rem)
	);

	// next probe address, wrapped into the table
	assign pos_sum  = (SW+1)'(rd_pos_q) + (SW+1)'(step_rem);
	assign nxt_pos  = (pos_sum >= (SW+1)'(size)) ? AW'(pos_sum - (SW+1)'(size)) : AW'(pos_sum);
	assign nxt_home = (nxt_pos == home_rem);

	// probe check on returned RAM word: {busy, owner}
	always_comb begin
		if (kind_q == KIND_INSERT) begin
			hit = !ram_rdata[MW-1];
		end else begin
			hit = ram_rdata[MW-1] && (ram_rdata[ID_WIDTH-1:0] == id_q);
		end
	end

	// walk ends on a hit or after the last slot of the probe cycle
	assign finish = (state_q == S_WALK) && chk_vld_s1 && (hit || chk_last_s1);

	// RAM port control
	assign ram_re = (state_q == S_WALK) && issue_q;
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_pos_s1;
		ram_wdata = {(kind_q == KIND_INSERT), id_q};
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if ((state_q == S_WALK) && chk_vld_s1 && hit) begin
			ram_we = 1'b1;
		end
	end

	spht_ram #(.WIDTH(MW), .DEPTH(TABLE_SLOTS)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_pos_q),
		.rdata (ram_rdata)
	);

	// sequencer and probe pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			mcnt_q      <= '0;
			issue_q     <= 1'b0;
			chk_vld_s1  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= finish;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TABLE_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						id_q    <= entry_id;
						mcnt_q  <= '0;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					mcnt_q <= mcnt_q + MCNT_W'(1);
					if (mcnt_q == MCNT_W'(MOD_STEPS - 1)) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					rd_pos_q   <= home_rem;
					issue_q    <= 1'b1;
					passed_q   <= '0;
					chk_vld_s1 <= 1'b0;
					state_q    <= S_WALK;
				end
				S_WALK: begin
					// issue stage: one read per cycle until back at home or until the walk finishes
					chk_vld_s1 <= issue_q && !finish;
					if (issue_q) begin
						chk_pos_s1  <= rd_pos_q;
						chk_last_s1 <= nxt_home;
						rd_pos_q    <= nxt_pos;
					end
					// check stage
					if (finish) begin
						issue_q  <= 1'b0;
						state_q  <= S_IDLE;
						if (hit) begin
							status_q <= ST_OK;
							slot_q   <= SLOT_W'(chk_pos_s1);
							probe_q  <= (kind_q == KIND_INSERT) ? COUNT_W'(passed_q) : '0;
						end else begin
							status_q <= (kind_q == KIND_INSERT) ? ST_FULL : ST_NOTFOUND;
							slot_q   <= '0;
							probe_q  <= '0;
						end
					end else begin
						if (issue_q) begin
							issue_q <= !nxt_home;
						end
						if (chk_vld_s1) begin
							passed_q <= passed_q + SW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign slot        = slot_q;
	assign probe_count = probe_q;
	assign status      = status_q;

endmodule
